### design/fnm_pkg.sv
`default_nettype none
package fnm_pkg;

  localparam int unsigned MaxPatternLen = 32;
  localparam int unsigned MaxNameLen    = 255;

  localparam int unsigned PatWords      = 4;
  localparam int unsigned CharsPerWord  = 8;
  localparam int unsigned CfgIdxW       = 3;

  localparam int unsigned ScoreExact     = 1000;
  localparam int unsigned ScoreSubBase   = 800;
  localparam int unsigned SeqStepBase    = 10;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PAT_LEN  = 3'd0,
    REG_PAT_A    = 3'd1,
    REG_PAT_B    = 3'd2,
    REG_PAT_C    = 3'd3,
    REG_PAT_D    = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_SEQ   = 2'd1,
    KIND_SUB   = 2'd2,
    KIND_EXACT = 2'd3
  } match_kind_e;

  // ASCII upper case to lower case, other bytes unchanged
  function automatic logic [7:0] fold_char(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### design/fuzzy_name_match_scorer.sv
`default_nettype none
// Fuzzy name match scorer. Stream the bytes of a name on s_axis, one byte per
// transfer, with tlast on the final byte; one result follows on m_axis per
// name: tdata[11:0] is the score, tuser[1:0] the match kind (none,
// subsequence, substring, exact). Matching folds ASCII A-Z to lower case.
// The block takes one byte every cycle while ready is high: each byte updates
// the shift-and match vector, the subsequence progress and the position
// counter, and the result is registered in the cycle after the last byte. Input
// ready drops only while a result sits in the output register and the sink
// stalls. Configure the pattern through the cfg port between names; register
// 0 is the pattern length, registers 1 to 4 hold the pattern bytes.
module fuzzy_name_match_scorer
  import fnm_pkg::*;
#(
  parameter int unsigned MAX_PATTERN_LEN = MaxPatternLen,
  parameter int unsigned MAX_NAME_LEN    = MaxNameLen
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // config write channel
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [63:0]         cfg_data_i,
  // input stream
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  wire logic [7:0]          s_axis_tdata_i,   // [7:0] name_char
  input  wire logic                s_axis_tlast_i,   // name_last
  // result stream
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output logic [15:0]              m_axis_tdata_o,   // [11:0] score, [15:12] zero
  output logic [1:0]               m_axis_tuser_o    // [1:0] match_kind
);

  localparam int unsigned P  = MAX_PATTERN_LEN;
  localparam int unsigned IW = (P > 1) ? $clog2(P) : 1;
  localparam int unsigned CW = $clog2(MAX_NAME_LEN + 1);

  // configuration
  logic [5:0]  pat_len_q;
  logic [63:0] pat_words_q [PatWords];

  // per-name state
  logic [P-1:0]  pmv_q,       pmv_d;
  logic          sub_seen_q,  sub_seen_d;
  logic [CW-1:0] sub_pos_q,   sub_pos_d;
  logic [CW-1:0] cpos_q,      cpos_d;
  logic [5:0]    seq_idx_q,   seq_idx_d;
  logic [5:0]    run_q,       run_d;
  logic [11:0]   seq_score_q, seq_score_d;

  // result register
  logic          out_valid_q;
  logic [11:0]   out_score_q, out_score_d;
  match_kind_e   out_kind_q,  out_kind_d;

  logic          in_xfer;
  logic [7:0]    c_fold;
  logic [5:0]    eff_len;
  logic [IW-1:0] len_m1;
  logic [P-1:0]  pat_eq;
  logic [P-1:0]  hits;
  logic          seq_hit;
  logic [5:0]    run_inc;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  assign c_fold = fold_char(s_axis_tdata_i);

  always_comb begin
    if (pat_len_q == 6'd0) begin
      eff_len = 6'd1;
    end else if (pat_len_q > 6'(P)) begin
      eff_len = 6'(P);
    end else begin
      eff_len = pat_len_q;
    end
  end

  assign len_m1 = IW'(eff_len - 6'd1);

  for (genvar i = 0; i < P; i++) begin : g_cmp
    assign pat_eq[i] = fold_char(pat_words_q[i / CharsPerWord][(i % CharsPerWord) * 8 +: 8])
                       == c_fold;
    assign hits[i]   = pat_eq[i] && (6'(i) < eff_len);
  end

  assign seq_hit = pat_eq[seq_idx_q[IW-1:0]];
  assign run_inc = run_q + 6'd1;

  always_comb begin
    pmv_d       = ((pmv_q << 1) | P'(1)) & hits;
    sub_seen_d  = sub_seen_q;
    sub_pos_d   = sub_pos_q;
    seq_idx_d   = seq_idx_q;
    run_d       = run_q;
    seq_score_d = seq_score_q;
    cpos_d      = cpos_q;

    if (!sub_seen_q && pmv_d[len_m1]) begin
      sub_seen_d = 1'b1;
      if (32'(cpos_q) >= 32'(len_m1)) begin
        sub_pos_d = CW'(32'(cpos_q) - 32'(len_m1));
      end else begin
        sub_pos_d = '0;
      end
    end

    if (seq_idx_q < eff_len) begin
      if (seq_hit) begin
        run_d       = run_inc;
        seq_score_d = seq_score_q + 12'(SeqStepBase)
                      + {4'd0, run_inc, 2'b00} + {6'd0, run_inc};
        seq_idx_d   = seq_idx_q + 6'd1;
      end else begin
        run_d = '0;
      end
    end

    if (32'(cpos_q) < 32'(MAX_NAME_LEN)) begin
      cpos_d = cpos_q + CW'(1);
    end
  end

  // score of the name that ends with this byte
  always_comb begin
    out_score_d = '0;
    out_kind_d  = KIND_NONE;
    if (sub_seen_d && (32'(cpos_d) == 32'(eff_len))) begin
      out_score_d = 12'(ScoreExact);
      out_kind_d  = KIND_EXACT;
    end else if (sub_seen_d) begin
      if (32'(sub_pos_d) < 32'(ScoreSubBase)) begin
        out_score_d = 12'(32'(ScoreSubBase) - 32'(sub_pos_d));
        out_kind_d  = KIND_SUB;
      end
    end else if (seq_idx_d >= eff_len) begin
      out_score_d = seq_score_d;
      out_kind_d  = KIND_SEQ;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q <= 6'd1;
      for (int w = 0; w < PatWords; w++) begin
        pat_words_q[w] <= '0;
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_PAT_LEN: pat_len_q      <= cfg_data_i[5:0];
        REG_PAT_A:   pat_words_q[0] <= cfg_data_i;
        REG_PAT_B:   pat_words_q[1] <= cfg_data_i;
        REG_PAT_C:   pat_words_q[2] <= cfg_data_i;
        REG_PAT_D:   pat_words_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pmv_q       <= '0;
      sub_seen_q  <= 1'b0;
      sub_pos_q   <= '0;
      cpos_q      <= '0;
      seq_idx_q   <= '0;
      run_q       <= '0;
      seq_score_q <= '0;
    end else if (in_xfer) begin
      if (s_axis_tlast_i) begin
        pmv_q       <= '0;
        sub_seen_q  <= 1'b0;
        sub_pos_q   <= '0;
        cpos_q      <= '0;
        seq_idx_q   <= '0;
        run_q       <= '0;
        seq_score_q <= '0;
      end else begin
        pmv_q       <= pmv_d;
        sub_seen_q  <= sub_seen_d;
        sub_pos_q   <= sub_pos_d;
        cpos_q      <= cpos_d;
        seq_idx_q   <= seq_idx_d;
        run_q       <= run_d;
        seq_score_q <= seq_score_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer && s_axis_tlast_i) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && s_axis_tlast_i) begin
      out_score_q <= out_score_d;
      out_kind_q  <= out_kind_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'd0, out_score_q};
  assign m_axis_tuser_o  = out_kind_q;

  // exact match always scores the fixed value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == KIND_EXACT) |-> m_axis_tdata_o[11:0] == 12'(ScoreExact))
    else $error("exact match with wrong score");

  // no match carries a zero score
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == KIND_NONE) |-> m_axis_tdata_o[11:0] == 12'd0)
    else $error("no-match result with nonzero score");

  // a byte that does not end a name produces no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !s_axis_tlast_i && (!out_valid_q || m_axis_tready_i) |=> !m_axis_tvalid_o)
    else $error("result without last byte");

  // subsequence progress stays within the pattern, the position counter within the name limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_idx_q <= 6'(P)) && (32'(cpos_q) <= 32'(MAX_NAME_LEN)))
    else $error("per-name counter out of range");

endmodule
`default_nettype wire

### tb/sv/tb_fuzzy_name_match_scorer.sv
`timescale 1ns / 100ps
module tb_fuzzy_name_match_scorer;
  import fnm_pkg::*;

  localparam int unsigned CycleLimit     = 400000;
  localparam int unsigned TargetChars    = 1100;
  localparam int unsigned SeqRunStep     = 5;
  localparam logic [CfgIdxW-1:0] RegFirstUnused = 3'd5;
  localparam logic [CfgIdxW-1:0] RegBeyondLast  = 3'd7;

  typedef struct packed {
    logic [11:0] score;
    match_kind_e kind;
  } name_result_t;

  // Tracks the pattern registers and the per-name match progress, and
  // queues one expected score for every name that ends.
  class match_score_tracker;
    bit [5:0]       pat_len_reg;
    bit [63:0]      pat_words [PatWords];
    bit [31:0]      prefix_vec;
    bit             sub_found;
    bit [7:0]       sub_start;
    bit [7:0]       char_pos;
    bit [5:0]       seq_pos;
    bit [5:0]       run_len;
    bit [11:0]      seq_total;
    name_result_t   expected_q [$];
    int unsigned    errors;

    function new();
      int i;
      pat_len_reg = 6'd1;
      for (i = 0; i < PatWords; i++) pat_words[i] = '0;
      errors = 0;
      clear_name();
    endfunction

    function void clear_name();
      prefix_vec = '0;
      sub_found  = 1'b0;
      sub_start  = '0;
      char_pos   = '0;
      seq_pos    = '0;
      run_len    = '0;
      seq_total  = '0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] data);
      case (idx)
        REG_PAT_LEN: pat_len_reg = data[5:0];
        REG_PAT_A, REG_PAT_B, REG_PAT_C, REG_PAT_D: pat_words[idx - REG_PAT_A] = data;
        default: ;
      endcase
    endfunction

    function int unsigned active_length();
      if (pat_len_reg == 0) return 1;
      if (pat_len_reg > MaxPatternLen) return MaxPatternLen;
      return pat_len_reg;
    endfunction

    function bit [7:0] lower(bit [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    function bit [7:0] folded_pattern_char(int unsigned i);
      return lower(pat_words[i / CharsPerWord][(i % CharsPerWord) * 8 +: 8]);
    endfunction

    function void absorb_char(logic [7:0] raw, logic last);
      int unsigned  len, idx, i;
      bit [31:0]    hits;
      bit [7:0]     ch;
      name_result_t res;
      len  = active_length();
      idx  = char_pos;
      ch   = lower(raw);
      hits = '0;
      for (i = 0; i < len; i++) begin
        if (folded_pattern_char(i) == ch) hits[i] = 1'b1;
      end
      prefix_vec = ((prefix_vec << 1) | 32'd1) & hits;
      // only the first full occurrence counts
      if (!sub_found && prefix_vec[len - 1]) begin
        sub_found = 1'b1;
        sub_start = (idx >= len - 1) ? 8'(idx - (len - 1)) : 8'd0;
      end
      if (seq_pos < len) begin
        if (folded_pattern_char(seq_pos) == ch) begin
          run_len++;
          seq_total += 12'(SeqStepBase + SeqRunStep * run_len);
          seq_pos++;
        end else begin
          run_len = '0;
        end
      end
      if (idx < MaxNameLen) char_pos = 8'(idx + 1);
      if (!last) return;
      res.score = '0;
      res.kind  = KIND_NONE;
      if (sub_found && char_pos == len) begin
        res.score = 12'(ScoreExact);
        res.kind  = KIND_EXACT;
      end else if (sub_found) begin
        if (sub_start < ScoreSubBase) begin
          res.score = 12'(ScoreSubBase - sub_start);
          res.kind  = KIND_SUB;
        end
      end else if (seq_pos >= len) begin
        res.score = seq_total;
        res.kind  = KIND_SEQ;
      end
      expected_q = {expected_q, res};
      clear_name();
    endfunction

    function void report(string what, int unsigned exp_val, int unsigned act_val);
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, what, exp_val, act_val);
    endfunction

    function void check_score(logic [15:0] data, logic [1:0] kind);
      name_result_t res;
      if (expected_q.size() == 0) begin
        report("result with no name pending, score", 0, data);
        return;
      end
      res = expected_q.pop_front();
      if (data !== {4'b0, res.score}) report("score", res.score, data);
      if (kind !== res.kind) report("match kind", res.kind, kind);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [63:0]         cfg_data = '0;
  logic                s_valid = 1'b0;
  logic [7:0]          s_data = '0;
  logic                s_last = 1'b0;
  logic                m_ready = 1'b0;
  logic                cfg_ready_o;
  logic                s_axis_tready_o;
  logic                m_axis_tvalid_o;
  logic [15:0]         m_axis_tdata_o;
  logic [1:0]          m_axis_tuser_o;

  match_score_tracker  tracker = new();
  logic [7:0]          pat_bytes [MaxPatternLen];
  logic [7:0]          name_q [$];
  bit                  quiet = 1'b0;
  int unsigned         chars_sent = 0;
  int unsigned         cycle_count = 0;

  always #5 clk_i = ~clk_i;

  fuzzy_name_match_scorer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [7:0] flip_case(logic [7:0] c);
    logic [7:0] low;
    low = c | 8'h20;
    if (low >= 8'h61 && low <= 8'h7A && $urandom_range(0, 1) == 1) return c ^ 8'h20;
    return c;
  endfunction

  // mostly pattern letters so the matchers get exercised, some raw bytes
  function automatic logic [7:0] filler_char(int unsigned len);
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return flip_case(pat_bytes[$urandom_range(0, len - 1)]);
  endfunction

  function automatic void append_char(logic [7:0] c);
    name_q = {name_q, c};
  endfunction

  task automatic send_char(input logic [7:0] ch, input logic last);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= ch;
    s_last  <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    tracker.absorb_char(ch, last);
    chars_sent++;
  endtask

  task automatic send_name();
    int i;
    for (i = 0; i < name_q.size(); i++) send_char(name_q[i], i == name_q.size() - 1);
  endtask

  // hold the input side idle until every score is back, then let the
  // pipeline settle before touching the registers
  task automatic drain_results();
    s_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    tracker.write_reg(idx, data);
  endtask

  task automatic load_pattern(input logic [5:0] len_val);
    logic [63:0] word;
    int          w, b;
    drain_results();
    word = {$urandom, $urandom};
    write_reg(REG_PAT_LEN, {word[63:6], len_val});
    for (w = 0; w < PatWords; w++) begin
      for (b = 0; b < CharsPerWord; b++) word[b * 8 +: 8] = pat_bytes[w * CharsPerWord + b];
      write_reg(CfgIdxW'(REG_PAT_A + w), word);
    end
    if ($urandom_range(0, 2) == 0) begin
      write_reg(CfgIdxW'($urandom_range(RegFirstUnused, RegBeyondLast)),
                {$urandom, $urandom});
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin : result_sink
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
      tracker.check_score(m_axis_tdata_o, m_axis_tuser_o);
    end
  end

  initial begin : stimulus
    int unsigned len_val, eff, names, phase, pick, k, drop, i;
    bit          raw_mode;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset pattern is a single zero byte
    name_q = '{8'h00};
    send_name();
    name_q = '{8'hFF};
    send_name();

    // pattern "aZ@": folding applies to Z, not to '@' or '`'
    for (i = 0; i < MaxPatternLen; i++) pat_bytes[i] = 8'($urandom_range(0, 255));
    pat_bytes[0] = 8'h61;
    pat_bytes[1] = 8'h5A;
    pat_bytes[2] = 8'h40;
    load_pattern(6'd3);
    name_q = '{8'h41, 8'h5A, 8'h40};
    send_name();
    name_q = '{8'h7B, 8'h61, 8'h7A, 8'h40};
    send_name();
    name_q = '{8'h61, 8'h71, 8'h7A, 8'h40};
    send_name();
    name_q = '{8'h61, 8'h7A, 8'h60};
    send_name();

    // write past the register list, pattern must stay as is
    drain_results();
    write_reg(RegBeyondLast, '1);
    cfg_valid <= 1'b0;
    name_q = '{8'h61, 8'h5A, 8'h40};
    send_name();

    // length zero behaves as one
    load_pattern(6'd0);
    name_q = '{8'h41};
    send_name();
    name_q = '{8'h62, 8'h61};
    send_name();

    phase = 0;
    while (chars_sent < TargetChars) begin
      if (phase % 4 == 0) begin
        case ((phase / 4) % 4)
          0:       len_val = MaxPatternLen;
          1:       len_val = 63;
          2:       len_val = 0;
          default: len_val = 1;
        endcase
      end else if ($urandom_range(0, 3) == 0) begin
        len_val = $urandom_range(0, 63);
      end else begin
        len_val = $urandom_range(1, 8);
      end
      raw_mode = ($urandom_range(0, 3) == 0);
      for (i = 0; i < MaxPatternLen; i++) begin
        pat_bytes[i] = raw_mode ? 8'($urandom_range(0, 255))
                                : flip_case(8'(8'h61 + $urandom_range(0, 5)));
      end
      quiet = ($urandom_range(0, 3) == 0);
      load_pattern(6'(len_val));
      eff   = tracker.active_length();
      names = (eff > 16) ? $urandom_range(3, 6) : $urandom_range(8, 14);
      repeat (names) begin
        name_q.delete();
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          for (i = 0; i < eff; i++) append_char(flip_case(pat_bytes[i]));
        end else if (pick < 40) begin
          repeat ($urandom_range(0, 6)) append_char(filler_char(eff));
          for (i = 0; i < eff; i++) append_char(flip_case(pat_bytes[i]));
          repeat ($urandom_range(0, 6)) append_char(filler_char(eff));
        end else if (pick < 65) begin
          for (i = 0; i < eff; i++) begin
            repeat ($urandom_range(0, 2)) append_char(filler_char(eff));
            append_char(flip_case(pat_bytes[i]));
          end
          repeat ($urandom_range(0, 2)) append_char(filler_char(eff));
        end else if (pick < 80) begin
          // one pattern character missing
          drop = $urandom_range(0, eff - 1);
          repeat ($urandom_range(0, 2)) append_char(filler_char(eff));
          for (i = 0; i < eff; i++) begin
            if (i != drop) append_char(flip_case(pat_bytes[i]));
          end
          if (name_q.size() == 0) append_char(filler_char(eff));
        end else if (pick < 98) begin
          k = $urandom_range(1, 12);
          repeat (k) append_char(filler_char(eff));
        end else begin
          // past the position counter's range
          repeat ($urandom_range(256, 300)) append_char(filler_char(eff));
          for (i = 0; i < eff; i++) append_char(flip_case(pat_bytes[i]));
        end
        send_name();
      end
      phase++;
    end

    drain_results();
    repeat (6) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
